FILE: rtl/sosw_pkg.sv
// Shared types, codes and constant tables for the sum-of-sines wave height block.
// Used by sosw_ctrl, sosw_datapath and sum_of_sines_wave_height; no dependencies.
package sosw_pkg;

	localparam int NUM_WAVES = 6;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int EVAL_STEPS = 13;
	localparam int SQRT_STEPS = 30;
	localparam int DIV_STEPS = 16;
	localparam logic [15:0] EPS_Q16 = 16'd6554;
	localparam logic [15:0] SCALE_RESET = 16'd256;
	localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

	localparam logic [1:0] CMD_TICK = 2'd0;
	localparam logic [1:0] CMD_HEIGHT = 2'd1;
	localparam logic [1:0] CMD_NORMAL = 2'd2;

	localparam logic [15:0] TICK_GAIN [NUM_WAVES] =
		'{16'd12516, 16'd15646, 16'd22947, 16'd18775, 16'd31291, 16'd43808};
	localparam logic [21:0] GAIN_X [NUM_WAVES] =
		'{22'd53404, 22'd106807, 22'd267018, 22'd480632, 22'd1201580, 22'd2136141};
	localparam logic [21:0] GAIN_Z [NUM_WAVES] =
		'{22'd42723, 22'd85446, 22'd213614, 22'd384505, 22'd961264, 22'd1708913};
	localparam logic [15:0] AMP_Q16 [NUM_WAVES] =
		'{16'd52429, 16'd32768, 16'd13107, 16'd9830, 16'd3277, 16'd1311};

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_TICK, OP_HSTART, OP_PH, OP_X2, OP_R1, OP_R2, OP_R3,
		OP_SC, OP_AMP, OP_TERM, OP_HEND, OP_SQA, OP_SQB, OP_SQ, OP_DIVI, OP_DIV,
		OP_DIVE, OP_PUB
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [2:0] comp;
		logic       sel;
		logic [1:0] samp;
		logic [1:0] nsel;
		logic       normal;
	} ctl_cmd_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [15:0]        time_step;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_z;
	} in_beat_t;

	typedef struct packed {
		logic               result_kind;
		logic signed [31:0] wave_height;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
	} out_beat_t;

endpackage

FILE: rtl/sosw_ctrl.sv
// Sequencer for the wave height block: walks ticks, height sums, root and divides.
// Depends on sosw_pkg; drives sosw_datapath through ctl_cmd_t.
module sosw_ctrl
	import sosw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_command,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output ctl_cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE, S_TICK, S_HSTART, S_EVAL, S_HEND, S_SQA, S_SQB, S_SQ,
		S_DIVI, S_DIV, S_DIVE, S_PUB
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic [2:0] comp_q;
	logic [1:0] samp_q;
	logic [1:0] nsel_q;
	logic       normal_q;
	logic       out_valid_q;
	logic       pub_fire;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign pub_fire = (state_q == S_PUB) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.op = OP_NOP;
		cmd.comp = comp_q;
		cmd.sel = (cnt_q >= 5'd5);
		cmd.samp = samp_q;
		cmd.nsel = nsel_q;
		cmd.normal = normal_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) cmd.op = OP_LOAD;
			S_TICK:   cmd.op = OP_TICK;
			S_HSTART: cmd.op = OP_HSTART;
			S_EVAL: begin
				case (cnt_q) inside
					5'd0, 5'd5:  cmd.op = OP_PH;
					5'd1, 5'd6:  cmd.op = OP_X2;
					5'd2, 5'd7:  cmd.op = OP_R1;
					5'd3, 5'd8:  cmd.op = OP_R2;
					5'd4, 5'd9:  cmd.op = OP_R3;
					5'd10:       cmd.op = OP_SC;
					5'd11:       cmd.op = OP_AMP;
					default:     cmd.op = OP_TERM;
				endcase
			end
			S_HEND:   cmd.op = OP_HEND;
			S_SQA:    cmd.op = OP_SQA;
			S_SQB:    cmd.op = OP_SQB;
			S_SQ:     cmd.op = OP_SQ;
			S_DIVI:   cmd.op = OP_DIVI;
			S_DIV:    cmd.op = OP_DIV;
			S_DIVE:   cmd.op = OP_DIVE;
			S_PUB:    if (pub_fire) cmd.op = OP_PUB;
			default:  cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			comp_q <= '0;
			samp_q <= '0;
			nsel_q <= '0;
			normal_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pub_fire) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					comp_q <= '0;
					samp_q <= '0;
					cnt_q <= '0;
					if (in_valid) begin
						unique case (in_command)
							CMD_TICK: state_q <= S_TICK;
							CMD_HEIGHT: begin
								normal_q <= 1'b0;
								state_q <= S_HSTART;
							end
							CMD_NORMAL: begin
								normal_q <= 1'b1;
								state_q <= S_HSTART;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_TICK: begin
					if (comp_q == 3'(NUM_WAVES - 1)) state_q <= S_IDLE;
					else comp_q <= comp_q + 3'd1;
				end
				S_HSTART: begin
					comp_q <= '0;
					cnt_q <= '0;
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (cnt_q == 5'(EVAL_STEPS - 1)) begin
						cnt_q <= '0;
						if (comp_q == 3'(NUM_WAVES - 1)) state_q <= S_HEND;
						else comp_q <= comp_q + 3'd1;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_HEND: begin
					if (!normal_q) state_q <= S_PUB;
					else if (samp_q == 2'd2) state_q <= S_SQA;
					else begin
						samp_q <= samp_q + 2'd1;
						state_q <= S_HSTART;
					end
				end
				S_SQA: state_q <= S_SQB;
				S_SQB: begin
					cnt_q <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					if (cnt_q == 5'(SQRT_STEPS - 1)) begin
						nsel_q <= '0;
						state_q <= S_DIVI;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_DIVI: begin
					cnt_q <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == 5'(DIV_STEPS - 1)) state_q <= S_DIVE;
					else cnt_q <= cnt_q + 5'd1;
				end
				S_DIVE: begin
					if (nsel_q == 2'd2) state_q <= S_PUB;
					else begin
						nsel_q <= nsel_q + 2'd1;
						state_q <= S_DIVI;
					end
				end
				S_PUB: if (pub_fire) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/sosw_datapath.sv
// Datapath: phases, sine polynomial, term accumulation, square root and divider.
// Depends on sosw_pkg; every register update but the cfg_we write of the scale is selected by the op from sosw_ctrl.
module sosw_datapath
	import sosw_pkg::*;
#(
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  in_beat_t    in_data,
	input  ctl_cmd_t    cmd,
	output out_beat_t   out_data
);

	localparam int STB = SINE_TABLE_BITS;

	logic [31:0]        tp_q [NUM_WAVES];
	logic [15:0]        scale_q;
	logic [15:0]        dt_q;
	logic signed [31:0] x_q, z_q, ex_q, ez_q;
	logic [15:0]        sx_q, sx2_q, sr_q;
	logic [1:0]         sq_q;
	logic signed [16:0] sa_q, sb_q;
	logic [30:0]        mag_q;
	logic               neg_q;
	logic [31:0]        amp_q;
	logic signed [31:0] acc_q, h_q;
	logic signed [28:0] dx_q, dz_q;
	logic [59:0]        v_q, res_q, bit_q;
	logic [45:0]        num_q, dv_q;
	logic [15:0]        quo_q;
	logic               qneg_q;
	logic signed [15:0] nx_q, ny_q, nz_q;
	out_beat_t          out_q;

	logic [31:0]        tick_prod;
	logic signed [31:0] pos_sel;
	logic [21:0]        gain_sel;
	logic signed [54:0] sp_prod;
	logic [31:0]        phase;
	logic [STB-1:0]     idx;
	logic [1:0]         quad;
	logic [14:0]        xraw;
	logic [15:0]        xq;
	logic [31:0]        sq_prod, r1_prod, r2_prod, r3_prod;
	logic signed [16:0] sine;
	logic signed [33:0] sc, sc_abs;
	logic [31:0]        amp_prod;
	logic [62:0]        term_prod, term_rnd;
	logic signed [31:0] term_s;
	logic signed [32:0] xe_sum, ze_sum;
	logic signed [31:0] xe, ze;
	logic signed [32:0] diff;
	logic signed [57:0] dx_sq, dz_sq;
	logic [59:0]        trial;
	logic signed [29:0] nval;
	logic [28:0]        nmag;
	logic [15:0]        qclamp;

	always_comb begin
		tick_prod = dt_q * TICK_GAIN[cmd.comp];
		pos_sel = cmd.sel ? ez_q : ex_q;
		gain_sel = cmd.sel ? GAIN_Z[cmd.comp] : GAIN_X[cmd.comp];
		sp_prod = pos_sel * $signed({1'b0, gain_sel});
		phase = sp_prod[39:8] + tp_q[cmd.comp] + (cmd.sel ? QUARTER_TURN : 32'd0);
		idx = phase[31 -: STB];
		quad = idx[STB-1 -: 2];
		xraw = {idx[STB-3:0], {(17 - STB){1'b0}}};
		xq = quad[0] ? (16'd32768 - {1'b0, xraw}) : {1'b0, xraw};
		sq_prod = sx_q * sx_q;
		r1_prod = 32'(16'd2320 * sx2_q);
		r2_prod = sr_q * sx2_q;
		r3_prod = sr_q * sx_q;
		sine = sq_q[1] ? -$signed({1'b0, r3_prod[30:15]}) : $signed({1'b0, r3_prod[30:15]});
		sc = sa_q * sb_q;
		sc_abs = sc[33] ? -sc : sc;
		amp_prod = AMP_Q16[cmd.comp] * scale_q;
		term_prod = 63'(mag_q) * 63'(amp_q);
		term_rnd = term_prod + (63'd1 << 37);
		term_s = $signed({7'd0, term_rnd[62:38]});
		// offset samples clamp at the top of the Q16.16 range
		xe_sum = {x_q[31], x_q} + 33'(EPS_Q16);
		ze_sum = {z_q[31], z_q} + 33'(EPS_Q16);
		xe = (xe_sum[32] != xe_sum[31]) ? 32'sh7fff_ffff : xe_sum[31:0];
		ze = (ze_sum[32] != ze_sum[31]) ? 32'sh7fff_ffff : ze_sum[31:0];
		diff = {acc_q[31], acc_q} - {h_q[31], h_q};
		dx_sq = dx_q * dx_q;
		dz_sq = dz_q * dz_q;
		trial = res_q + bit_q;
		case (cmd.nsel)
			2'd0:    nval = -30'(dx_q);
			2'd1:    nval = $signed({14'd0, EPS_Q16});
			default: nval = -30'(dz_q);
		endcase
		nmag = nval[29] ? 29'(-nval) : 29'(nval);
		qclamp = (quo_q > 16'd16384) ? 16'd16384 : quo_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WAVES; i++) tp_q[i] <= '0;
			scale_q <= SCALE_RESET;
		end else begin
			if (cfg_we) scale_q <= cfg_data;
			if (cmd.op == OP_TICK) tp_q[cmd.comp] <= tp_q[cmd.comp] + tick_prod;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				dt_q <= in_data.time_step;
				x_q <= in_data.pos_x;
				z_q <= in_data.pos_z;
			end
			OP_HSTART: begin
				acc_q <= '0;
				ex_q <= (cmd.samp == 2'd1) ? xe : x_q;
				ez_q <= (cmd.samp == 2'd2) ? ze : z_q;
			end
			OP_PH: begin
				sx_q <= xq;
				sq_q <= quad;
			end
			OP_X2: sx2_q <= sq_prod[30:15];
			OP_R1: sr_q <= 16'd21024 - r1_prod[30:15];
			OP_R2: sr_q <= 16'd51472 - r2_prod[30:15];
			OP_R3: begin
				if (cmd.sel) sb_q <= sine;
				else sa_q <= sine;
			end
			OP_SC: begin
				mag_q <= sc_abs[30:0];
				neg_q <= sc[33];
			end
			OP_AMP: amp_q <= amp_prod;
			OP_TERM: acc_q <= neg_q ? (acc_q - term_s) : (acc_q + term_s);
			OP_HEND: begin
				case (cmd.samp)
					2'd0:    h_q <= acc_q;
					2'd1:    dx_q <= diff[28:0];
					default: dz_q <= diff[28:0];
				endcase
			end
			OP_SQA: begin
				v_q <= 60'(dx_sq);
				res_q <= '0;
				bit_q <= 60'd1 << 58;
			end
			OP_SQB: v_q <= v_q + 60'(dz_sq) + 60'(EPS_Q16 * EPS_Q16);
			OP_SQ: begin
				if (v_q >= trial) begin
					v_q <= v_q - trial;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			OP_DIVI: begin
				num_q <= (46'(nmag) << 14) + 46'(res_q[29:1]);
				dv_q <= 46'(res_q[29:0]) << 15;
				quo_q <= '0;
				qneg_q <= nval[29];
			end
			OP_DIV: begin
				if (num_q >= dv_q) num_q <= num_q - dv_q;
				quo_q <= {quo_q[14:0], (num_q >= dv_q)};
				dv_q <= dv_q >> 1;
			end
			OP_DIVE: begin
				case (cmd.nsel)
					2'd0:    nx_q <= qneg_q ? -$signed(qclamp) : $signed(qclamp);
					2'd1:    ny_q <= qneg_q ? -$signed(qclamp) : $signed(qclamp);
					default: nz_q <= qneg_q ? -$signed(qclamp) : $signed(qclamp);
				endcase
			end
			OP_PUB: begin
				out_q.result_kind <= cmd.normal;
				out_q.wave_height <= h_q;
				out_q.normal_x <= cmd.normal ? nx_q : 16'sd0;
				out_q.normal_y <= cmd.normal ? ny_q : 16'sd0;
				out_q.normal_z <= cmd.normal ? nz_q : 16'sd0;
			end
			default: ;
		endcase
	end

	assign out_data = out_q;

endmodule

FILE: rtl/sum_of_sines_wave_height.sv
// Top level of the sum-of-sines sea surface generator.
// Depends on sosw_pkg, sosw_ctrl and sosw_datapath.
//
// Input beats (in_valid/in_ready) carry a command: tick advances the six
// wave phases by time_step, height returns the summed height at pos_x,pos_z,
// normal returns the height plus the unit surface normal there. Command 3
// is taken and dropped. Output beats (out_valid/out_ready) carry one result
// for height and normal commands, none for ticks.
// One item is worked at a time; in_ready is high only while idle.
// A tick updates the six phases one per step; a height sums six components
// one after another, 13 steps each; a normal runs three height sums, then a
// 30-step square root and three 16-step divides. The next item is taken
// the cycle after the result is registered.
// The result register holds its beat while out_ready is low; a finished
// item then waits in its last step until the register frees up.
// cfg_we writes amplitude_scale (Q8.8); the user must write it only while idle, the block does not enforce this.
// Reset zeroes the phases and sets amplitude_scale to 1.0; no clearing pass.
module sum_of_sines_wave_height
	import sosw_pkg::*;
#(
	parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_beat_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_beat_t   out_data
);

	ctl_cmd_t cmd;

	sosw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (in_data.command),
		.in_ready   (in_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cmd        (cmd)
	);

	sosw_datapath #(
		.SINE_TABLE_BITS (SINE_TABLE_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_data  (in_data),
		.cmd      (cmd),
		.out_data (out_data)
	);

endmodule

FILE: bench/sum_of_sines_wave_height_tb.sv
// Testbench for sum_of_sines_wave_height: drives tick, height and normal commands and
// checks every result beat against a bit-accurate predictor of the wave field.
// Depends on sosw_pkg and the sum_of_sines_wave_height RTL.
module sum_of_sines_wave_height_tb;
	import sosw_pkg::*;

	localparam int TBL_BITS = 10;
	localparam int WDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES = 400;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_ready;
	in_beat_t in_data;
	logic out_valid;
	logic out_ready;
	out_beat_t out_data;

	logic [31:0] wave_phase [NUM_WAVES];
	logic [15:0] amp_scale;
	out_beat_t pending_results [$];
	int errors;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	bit timed_out;

	sum_of_sines_wave_height uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Q15 sine of a 32-bit turn phase, polynomial over one quadrant
	function automatic longint sine_q15(logic [31:0] p);
		logic [31:0] idx;
		logic [1:0] quad;
		longint unsigned x, x2, r;
		idx = p >> (32 - TBL_BITS);
		quad = idx[TBL_BITS-1 -: 2];
		x = longint'(idx & ((32'd1 << (TBL_BITS - 2)) - 1)) << (17 - TBL_BITS);
		if (quad[0]) begin
			x = 32768 - x;
		end
		x2 = (x * x) >> 15;
		r = (2320 * x2) >> 15;
		r = 21024 - r;
		r = (r * x2) >> 15;
		r = 51472 - r;
		r = (r * x) >> 15;
		return quad[1] ? -longint'(r) : longint'(r);
	endfunction

	function automatic logic [31:0] space_phase(longint pos, longint unsigned gain);
		longint unsigned prod;
		prod = longint'(pos) * gain;
		return prod[39:8];
	endfunction

	function automatic longint wave_sum(longint x, longint z);
		longint sum, sc, q;
		logic [31:0] pa, pb;
		longint unsigned amp, mag;
		sum = 0;
		for (int i = 0; i < NUM_WAVES; i++) begin
			pa = space_phase(x, GAIN_X[i]) + wave_phase[i];
			pb = space_phase(z, GAIN_Z[i]) + wave_phase[i] + QUARTER_TURN;
			sc = sine_q15(pa) * sine_q15(pb);
			amp = longint'(AMP_Q16[i]) * longint'(amp_scale);
			mag = longint'(sc < 0 ? -sc : sc) * amp;
			q = longint'((mag + (64'd1 << 37)) >> 38);
			sum += (sc < 0) ? -q : q;
		end
		if (sum > 64'sd2147483647) begin
			sum = 64'sd2147483647;
		end
		if (sum < -64'sd2147483648) begin
			sum = -64'sd2147483648;
		end
		return sum;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) begin
			b >>= 2;
		end
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] unit_part(longint v, longint unsigned len);
		longint unsigned mag, q;
		mag = longint'(v < 0 ? -v : v);
		q = (mag * 16384 + len / 2) / len;
		if (q > 16384) begin
			q = 16384;
		end
		return (v < 0) ? 16'(-longint'(q)) : 16'(q);
	endfunction

	function automatic longint nudge(longint p);
		longint r;
		r = p + EPS_Q16;
		return (r > 64'sd2147483647) ? 64'sd2147483647 : r;
	endfunction

	// advances the phases for ticks, queues the expected beat for height/normal
	task automatic predict_surface(in_beat_t b);
		out_beat_t e;
		longint x, z, h, dx, dz;
		longint unsigned len;
		x = b.pos_x;
		z = b.pos_z;
		if (b.command == CMD_TICK) begin
			for (int i = 0; i < NUM_WAVES; i++) begin
				wave_phase[i] += 32'(b.time_step) * 32'(TICK_GAIN[i]);
			end
		end else if (b.command != CMD_UNUSED) begin
			e = '0;
			h = wave_sum(x, z);
			e.wave_height = 32'(h);
			if (b.command == CMD_NORMAL) begin
				e.result_kind = 1'b1;
				dx = wave_sum(nudge(x), z) - h;
				dz = wave_sum(x, nudge(z)) - h;
				len = int_sqrt(longint'(dx * dx) + longint'(dz * dz)
					+ longint'(EPS_Q16) * longint'(EPS_Q16));
				e.normal_x = unit_part(-dx, len);
				e.normal_y = unit_part(longint'(EPS_Q16), len);
				e.normal_z = unit_part(-dz, len);
			end
			pending_results.push_back(e);
		end
	endtask

	task automatic send_beat(logic [1:0] cmd, logic [15:0] dt, logic [31:0] px,
			logic [31:0] pz);
		in_beat_t b;
		b.command = cmd;
		b.time_step = dt;
		b.pos_x = px;
		b.pos_z = pz;
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		predict_surface(b);
		@(negedge clk);
		in_valid <= 1'b0;
		// valid drops before the next beat so the next beat starts on a later edge
		@(negedge clk);
	endtask

	task automatic drain_results();
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (10) @(negedge clk);
	endtask

	// idle-only register write
	task automatic set_scale(logic [15:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		amp_scale = v;
	endtask

	function automatic logic [31:0] rand_pos();
		case ($urandom_range(3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(200)) - 100) <<< 16;
			default: return 32'($signed($urandom_range(131072)) - 65536) <<< 8;
		endcase
	endfunction

	task automatic test_directed();
		send_beat(CMD_HEIGHT, 16'h0, 32'h0, 32'h0);
		send_beat(CMD_NORMAL, 16'h0, 32'h0, 32'h0);
		send_beat(CMD_NORMAL, 16'h0, 32'h7fff_ffff, 32'h7fff_ffff);
		send_beat(CMD_NORMAL, 16'h0, 32'h8000_0000, 32'h8000_0000);
		send_beat(CMD_HEIGHT, 16'hffff, 32'hffff_ffff, 32'h0001_0000);
		send_beat(CMD_TICK, 16'hffff, 32'hffff_ffff, 32'hffff_ffff);
		send_beat(CMD_HEIGHT, 16'h0, 32'h7fff_0000, 32'h8000_0000);
		send_beat(CMD_UNUSED, 16'h1234, 32'h5555_5555, 32'haaaa_aaaa);
		send_beat(CMD_NORMAL, 16'h0, 32'h7fff_e000, 32'h0);
		send_beat(CMD_TICK, 16'h0, 32'h0, 32'h0);
		send_beat(CMD_HEIGHT, 16'h0, 32'haaaa_aaaa, 32'h5555_5555);
		send_beat(CMD_TICK, 16'h8001, 32'h0, 32'h0);
		send_beat(CMD_NORMAL, 16'h0, 32'h0003_0000, 32'hfffd_0000);
	endtask

	task automatic test_scale_extremes();
		set_scale(16'hffff);
		send_beat(CMD_HEIGHT, 16'h0, 32'h0, 32'h0);
		send_beat(CMD_NORMAL, 16'h0, 32'h0010_0000, 32'h0020_0000);
		set_scale(16'h0000);
		send_beat(CMD_HEIGHT, 16'h0, 32'h0010_0000, 32'h0);
		send_beat(CMD_NORMAL, 16'h0, 32'h0, 32'h0010_0000);
		set_scale(16'd256);
	endtask

	task automatic test_random(int count);
		logic [1:0] cmd;
		for (int n = 0; n < count; n++) begin
			if (n % 200 == 199) begin
				set_scale((n % 400 == 199) ? 16'($urandom) : 16'($urandom_range(1024)));
			end
			case ($urandom_range(9)) inside
				0, 1: cmd = CMD_TICK;
				2, 3, 4, 5: cmd = CMD_HEIGHT;
				9: cmd = ($urandom_range(3) == 0) ? CMD_UNUSED : CMD_NORMAL;
				default: cmd = CMD_NORMAL;
			endcase
			send_beat(cmd, 16'($urandom), rand_pos(), rand_pos());
			// let the queue run dry once per batch
			if (n == count / 2) begin
				drain_results();
			end
		end
	endtask

	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected: %p", $time, out_data);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (out_data.result_kind !== e.result_kind
						|| out_data.wave_height !== e.wave_height
						|| out_data.normal_x !== e.normal_x
						|| out_data.normal_y !== e.normal_y
						|| out_data.normal_z !== e.normal_z) begin
					$display("%0t: mismatch expected %p actual %p", $time, e, out_data);
					errors++;
				end
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog on cycles with no beat moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles == WDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("sum_of_sines_wave_height verification failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		timed_out = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		amp_scale = SCALE_RESET;
		for (int i = 0; i < NUM_WAVES; i++) begin
			wave_phase[i] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_scale_extremes();
		send_idle_pct = 8;
		recv_stall_pct = 61;
		test_random(600);
		send_idle_pct = 61;
		recv_stall_pct = 8;
		test_random(600);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		test_random(600);

		drain_results();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0) begin
			$display("sum_of_sines_wave_height verification clean");
		end else begin
			$display("sum_of_sines_wave_height verification failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/sosw_pkg.sv
rtl/sosw_ctrl.sv
rtl/sosw_datapath.sv
rtl/sum_of_sines_wave_height.sv
bench/sum_of_sines_wave_height_tb.sv
